FILE: sv/phr_pkg.sv
// ----------------------------------------------------------------------------
// phr_pkg: shared types and arithmetic helpers
// types, constants and small functions used by the hue rotation pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package phr_pkg;

  localparam int unsigned StepsStage = 3;

  localparam logic [10:0] HueOfs256  = 11'd256;
  localparam logic [10:0] HueOfs768  = 11'd768;
  localparam logic [10:0] HueOfs1280 = 11'd1280;

  // state of one restoring divider in flight
  typedef struct packed {
    logic [15:0] rem;
    logic [8:0]  q;
    logic [8:0]  den;
  } div_t;

  // request after the front stage
  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  l;
    logic        gray;
    logic [10:0] hofs;
    logic        hneg;
    div_t        ds;
    div_t        dh;
  } front_t;

  // one quotient bit: compare against the divisor shifted by k
  function automatic div_t div_step(input div_t x, input int k);
    logic [16:0] sh;
    logic [16:0] r;
    div_t        y;
    y  = x;
    sh = 17'(x.den) << k;
    r  = {1'b0, x.rem};
    if (r >= sh) begin
      y.rem  = 16'(r - sh);
      y.q[k] = 1'b1;
    end
    return y;
  endfunction

  // floor(n / 255) by reciprocal with a one-step correction
  function automatic logic [9:0] div255(input logic [17:0] n);
    logic [33:0] prod;
    logic [9:0]  q0;
    logic signed [19:0] r;
    prod = 34'(n) * 34'd32897;
    q0   = 10'(prod >> 23);
    r    = 20'(signed'({2'b0, n})) - 20'(signed'({1'b0, 10'(q0) * 18'd0 + 18'(q0) * 18'd255}));
    if (r < 0) begin
      q0 = q0 - 10'd1;
    end else if (r >= 20'sd255) begin
      q0 = q0 + 10'd1;
    end
    return q0;
  endfunction

  // floor(n / 6) for n below 2048
  function automatic logic [8:0] div6(input logic [10:0] n);
    logic [27:0] prod;
    prod = 28'(n) * 28'd43691;
    return 9'(prod >> 18);
  endfunction

  // start of each hue sector on the 0..255 scale
  function automatic logic [7:0] sector_base(input logic [2:0] sec);
    logic [7:0] b;
    case (sec)
      3'd1:    b = 8'd42;
      3'd2:    b = 8'd85;
      3'd3:    b = 8'd128;
      3'd4:    b = 8'd170;
      3'd5:    b = 8'd213;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pixel_hue_rotate_hsl.sv
// throughput: one pixel per clock while the output is not stalled; every stage holds one request
// the saturation and hue dividers are split over three slices of three bits
// stalls back up stage by stage, empty stages still fill while output waits
// reset (rst, synchronous, active high) empties the pipe and sets hue_shift 0
// ----------------------------------------------------------------------------
// pixel_hue_rotate_hsl: ARGB hue rotation through integer HSL
// rgb to hsl, add hue shift modulo 256, rebuild rgb; alpha passes through
// ----------------------------------------------------------------------------
`default_nettype none
module pixel_hue_rotate_hsl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,      // hue_shift
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // pixel_in[31:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // pixel_out[31:0]
);
  import phr_pkg::*;

  // configured hue offset; the user must write it only while the pipe is empty, the block does not enforce this
  logic [7:0] hue_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift <= 8'd0;
    end else if (cfg_we) begin
      hue_shift <= cfg_wdata;
    end
  end

  // stage links: valid/ready pair plus the request carried along
  front_t f_data, d1_data, d2_data, d3_data;
  logic   f_vld, f_rdy, d1_vld, d1_rdy, d2_vld, d2_rdy, d3_vld, d3_rdy;

  // stage 0: max, min, lightness, divider setup
  phr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (s_axis_tdata),
    .out_valid (f_vld),
    .out_ready (f_rdy),
    .out_data  (f_data)
  );

  // stages 1..3: quotient bits 8..6, 5..3, 2..0
  phr_div #(.HI(8)) u_div0 (
    .clk (clk), .rst (rst),
    .in_valid (f_vld), .in_ready (f_rdy), .in_data (f_data),
    .out_valid (d1_vld), .out_ready (d1_rdy), .out_data (d1_data)
  );

  phr_div #(.HI(5)) u_div1 (
    .clk (clk), .rst (rst),
    .in_valid (d1_vld), .in_ready (d1_rdy), .in_data (d1_data),
    .out_valid (d2_vld), .out_ready (d2_rdy), .out_data (d2_data)
  );

  phr_div #(.HI(2)) u_div2 (
    .clk (clk), .rst (rst),
    .in_valid (d2_vld), .in_ready (d2_rdy), .in_data (d2_data),
    .out_valid (d3_vld), .out_ready (d3_rdy), .out_data (d3_data)
  );

  // stages 4..7: hue shift, v/y, ramp, channel rebuild into output register
  phr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hue_shift (hue_shift),
    .in_valid  (d3_vld),
    .in_ready  (d3_rdy),
    .in_data   (d3_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pixel     (m_axis_tdata)
  );

`ifndef SYNTH
  // requests in flight: accepted but not yet delivered
  logic [3:0] inflight;
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 4'd0;
    end else begin
      inflight <= 4'(inflight + 4'(s_axis_tvalid && s_axis_tready)
                  - 4'(m_axis_tvalid && m_axis_tready));
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst) inflight <= 4'd8)
    else $error("more requests in flight than pipeline stages");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != 4'd0)
    else $error("output request without a matching input");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

FILE: sv/phr_front.sv
// ----------------------------------------------------------------------------
// phr_front: channel analysis stage
// finds max, min, lightness and sets up the saturation and hue divisions
// ----------------------------------------------------------------------------
`default_nettype none
module phr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     pixel,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output phr_pkg::front_t      out_data
);
  import phr_pkg::*;

  logic [7:0]  r, g, b, mx, mn, c, d;
  logic [8:0]  sum, den;
  front_t      nxt;

  always_comb begin
    r   = pixel[23:16];
    g   = pixel[15:8];
    b   = pixel[7:0];
    mx  = (r > g) ? r : g;
    mx  = (mx > b) ? mx : b;
    mn  = (r < g) ? r : g;
    mn  = (mn < b) ? mn : b;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    den = (sum[8:1] <= 8'd128) ? sum : 9'(10'd512 - {1'b0, sum});
    // hue sector selection, six cases
    if (r == mx) begin
      if (g == mn) begin nxt.hofs = HueOfs1280; nxt.hneg = 1'b0; c = b; end
      else begin nxt.hofs = HueOfs256; nxt.hneg = 1'b1; c = g; end
    end else if (g == mx) begin
      if (b == mn) begin nxt.hofs = HueOfs256; nxt.hneg = 1'b0; c = r; end
      else begin nxt.hofs = HueOfs768; nxt.hneg = 1'b1; c = b; end
    end else begin
      if (r == mn) begin nxt.hofs = HueOfs768; nxt.hneg = 1'b0; c = g; end
      else begin nxt.hofs = HueOfs1280; nxt.hneg = 1'b1; c = r; end
    end
    nxt.alpha  = pixel[31:24];
    nxt.l      = sum[8:1];
    nxt.gray   = (d == 8'd0);
    nxt.ds.rem = {d, 8'd0};
    nxt.ds.q   = '0;
    nxt.ds.den = den;
    nxt.dh.rem = {8'(mx - c), 8'd0};
    nxt.dh.q   = '0;
    nxt.dh.den = {1'b0, d};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/phr_div.sv
// ----------------------------------------------------------------------------
// phr_div: divider slice
// three restoring quotient bits for both the saturation and hue divisions
// ----------------------------------------------------------------------------
`default_nettype none
module phr_div #(
  parameter int HI = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  phr_pkg::front_t      in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output phr_pkg::front_t      out_data
);
  import phr_pkg::*;

  front_t nxt;

  always_comb begin
    nxt = in_data;
    for (int i = 0; i < int'(StepsStage); i++) begin
      nxt.ds = div_step(nxt.ds, HI - i);
      nxt.dh = div_step(nxt.dh, HI - i);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/phr_back.sv
// ----------------------------------------------------------------------------
// phr_back: hue shift and rgb rebuild
// four stages: hue and products, v and y, ramp product, channel select
// ----------------------------------------------------------------------------
`default_nettype none
module phr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      hue_shift,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  phr_pkg::front_t      in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          pixel
);
  import phr_pkg::*;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  l;
    logic [8:0]  s;
    logic        lt;
    logic [15:0] vnum;
    logic [2:0]  sec;
    logic [8:0]  t;
  } st1_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [8:0]  v;
    logic [8:0]  y;
    logic [2:0]  sec;
    logic [8:0]  t;
  } st2_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [8:0]  v;
    logic [8:0]  y;
    logic [2:0]  sec;
    logic [17:0] p;
  } st3_t;

  logic [3:0] vld;
  logic [3:0] rdy;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  logic [31:0] pix_next;

  // stage 1: hue, shift, sector and v numerator
  logic [10:0] hsum;
  logic [8:0]  h6;
  logic [8:0]  hs;
  logic [7:0]  h;
  logic [10:0] h6x;
  always_comb begin
    hsum = in_data.hneg ? (in_data.hofs - 11'(in_data.dh.q))
                        : (in_data.hofs + 11'(in_data.dh.q));
    h6   = in_data.gray ? 9'd0 : div6(hsum);
    hs   = h6 + {1'b0, hue_shift};
    h    = hs[7:0];
    h6x  = 11'(h) * 11'd6;
    s1_next.alpha = in_data.alpha;
    s1_next.l     = in_data.l;
    s1_next.s     = in_data.gray ? 9'd0 : in_data.ds.q;
    s1_next.lt    = (in_data.l < 8'd128);
    s1_next.sec   = h6x[10:8];
    s1_next.t     = 9'(9'(h - sector_base(h6x[10:8])) * 9'd6);
    s1_next.vnum  = s1_next.lt ? 16'(17'(in_data.l) * (17'd255 + 17'(s1_next.s)))
                               : 16'(17'(in_data.l) * 17'(s1_next.s));
  end

  // stage 2: v and y
  logic [9:0] q1;
  always_comb begin
    q1 = div255({2'b0, s1.vnum});
    s2_next.alpha = s1.alpha;
    s2_next.sec   = s1.sec;
    s2_next.t     = s1.t;
    s2_next.v     = s1.lt ? q1[8:0] : 9'(10'(s1.l) + 10'(s1.s) - q1);
    s2_next.y     = 9'({s1.l, 1'b0} - s2_next.v);
  end

  // stage 3: ramp product
  always_comb begin
    s3_next.alpha = s2.alpha;
    s3_next.v     = s2.v;
    s3_next.y     = s2.y;
    s3_next.sec   = s2.sec;
    s3_next.p     = 18'(s2.v - s2.y) * 18'(s2.t);
  end

  // stage 4: x, z and channel order
  logic [9:0] px, pz;
  logic [10:0] xs;
  logic signed [11:0] zs;
  logic [8:0] x, z, cr, cg, cb;
  always_comb begin
    px = div255(s3.p);
    pz = div255(18'(s3.p + 18'd254));
    xs = 11'(s3.y) + 11'(px);
    x  = (xs > 11'd255) ? 9'd255 : xs[8:0];
    zs = 12'(signed'({3'b0, s3.v})) - 12'(signed'({2'b0, pz}));
    z  = (zs < 0) ? 9'd0 : zs[8:0];
    case (s3.sec)
      3'd1:    begin cr = z;    cg = s3.v; cb = s3.y; end
      3'd2:    begin cr = s3.y; cg = s3.v; cb = x;    end
      3'd3:    begin cr = s3.y; cg = z;    cb = s3.v; end
      3'd4:    begin cr = x;    cg = s3.y; cb = s3.v; end
      3'd5:    begin cr = s3.v; cg = s3.y; cb = z;    end
      default: begin cr = s3.v; cg = x;    cb = s3.y; end
    endcase
    pix_next = {s3.alpha, 24'd0} | (32'(cr) << 16) | (32'(cg) << 8) | 32'(cb);
  end

  assign rdy[3]   = !vld[3] || out_ready;
  assign rdy[2]   = !vld[2] || rdy[3];
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy[0]) s1 <= s1_next;
    if (vld[0] && rdy[1]) s2 <= s2_next;
    if (vld[1] && rdy[2]) s3 <= s3_next;
    if (vld[2] && rdy[3]) pixel <= pix_next;
  end

endmodule
`default_nettype wire
